// ----- rtl/core/bfss_pkg.sv -----
// ----------------------------------------------------------------------------
// bfss_pkg
// Shared types and constants of the bitplane fetch slot sequencer: the plane
// request word, the latched fetch group context and the register indexes.
// ----------------------------------------------------------------------------
package bfss_pkg;

    localparam int REQUEST_DELAY_DEF = 3;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;

    localparam int PC_COUNT_LSB  = 12;
    localparam int PC_SHRES_BIT  = 6;
    localparam int PC_HIRES_BIT  = 15;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PLANE_CONTROL     = 3'd0,
        CFG_FETCH_START       = 3'd1,
        CFG_FETCH_STOP        = 3'd2,
        CFG_ENHANCED_MODE     = 3'd3,
        CFG_HARD_STOP_DISABLE = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic       modulo;
        logic [2:0] plane;
    } plane_req_t;

    typedef struct packed {
        logic [2:0] plane_count;
        logic       hires;
        logic       super_hires;
        logic       modulo_pending;
    } slot_ctx_t;

endpackage

// ----- rtl/core/bfss_slot_decode.sv -----
// ----------------------------------------------------------------------------
// bfss_slot_decode
// Maps a fetch group slot to the plane request for lores, hires and
// super-hires groups, with the modulo flag on the last fetch of each plane.
// ----------------------------------------------------------------------------
module bfss_slot_decode
    import bfss_pkg::*;
(
    input  slot_ctx_t  ctx,
    input  logic [3:0] slot,
    output plane_req_t req
);

    logic [2:0] hires_plane;
    logic [2:0] n;
    logic       m;

    assign n = ctx.plane_count;
    assign m = ctx.modulo_pending;

    always_comb begin
        case (slot[1:0])
            2'd0:    hires_plane = 3'd4;
            2'd1:    hires_plane = 3'd2;
            2'd2:    hires_plane = 3'd3;
            default: hires_plane = 3'd1;
        endcase
    end

    always_comb begin
        req = '0;
        if (!slot[3]) begin
            if (ctx.super_hires) begin
                if (!slot[0]) begin
                    if (n >= 3'd2) begin
                        req = '{modulo: (slot == 4'd6) & m, plane: 3'd2};
                    end
                end else if (n >= 3'd1) begin
                    req = '{modulo: (slot == 4'd7) & m, plane: 3'd1};
                end
            end else if (ctx.hires) begin
                if (n >= hires_plane) begin
                    req = '{modulo: slot[2] & m, plane: hires_plane};
                end
            end else begin
                case (slot)
                    4'd1: if (n >= 3'd4) req = '{modulo: m, plane: 3'd4};
                    4'd2: if (n == 3'd6) req = '{modulo: m, plane: 3'd6};
                    4'd3: if (n >= 3'd2) req = '{modulo: m, plane: 3'd2};
                    4'd5: if (n >= 3'd3) req = '{modulo: m, plane: 3'd3};
                    4'd6: if (n == 3'd5 || n == 3'd6) req = '{modulo: m, plane: 3'd5};
                    4'd7: if (n >= 3'd1) req = '{modulo: m, plane: 3'd1};
                    default: req = '0;
                endcase
            end
        end
    end

endmodule

// ----- rtl/core/bitplane_fetch_slot_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// bitplane_fetch_slot_sequencer_unit
// Bitplane DMA fetch sequencer: start/stop control, 8-slot fetch groups and
// a plane request delay line, one colour clock per request.
// ----------------------------------------------------------------------------
// Each request carries one colour clock (position, DMA enable, window state,
// hard stop clear) and yields exactly one result: the plane fetch issued in
// that clock, if any, with its modulo flag, plus the active and sprite
// inhibit flags. A request is taken every clock while the result side keeps
// up. The result is registered: the input register holds the request while
// the control and slot step are evaluated, and the result register is loaded
// from them when the request advances. A result held by the receiver
// holds the input register and stalls the input side.
// Plane requests pass through the delay line, which shifts only in active
// clocks. Configuration writes take effect at once and should be made only
// while no request is in flight.
// ----------------------------------------------------------------------------
module bitplane_fetch_slot_sequencer_unit
    import bfss_pkg::*;
#(
    parameter int REQUEST_DELAY = REQUEST_DELAY_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_hpos,
    input  logic                   s_plane_dma_enable,
    input  logic                   s_window_open,
    input  logic                   s_clear_hard_stop,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_fetch_valid,
    output logic [2:0]             m_fetch_plane,
    output logic                   m_add_modulo,
    output logic                   m_dma_active,
    output logic                   m_sprite_inhibit
);

    localparam int DEPTH = REQUEST_DELAY + 1;

    localparam logic [1:0] SM_NONE    = 2'd0;
    localparam logic [1:0] SM_ARMED   = 2'd1;
    localparam logic [1:0] SM_STOPPED = 2'd2;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_START  = 5'b00010,
        PH_FETCH  = 5'b00100,
        PH_STOP   = 5'b01000,
        PH_FINISH = 5'b10000
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [3:0] slot;
        logic [2:0] plane_count;
        logic       hires;
        logic       super_hires;
        logic       modulo_pending;
        logic       draining;
        logic       stop_pending;
        logic       hard_stop;
        logic [1:0] start_match;
        logic       enable_before;
        logic       active;
        logic       inhibit;
    } seq_state_t;

    localparam seq_state_t ST_RESET = '{
        phase:          PH_IDLE,
        slot:           4'd0,
        plane_count:    3'd0,
        hires:          1'b0,
        super_hires:    1'b0,
        modulo_pending: 1'b0,
        draining:       1'b0,
        stop_pending:   1'b0,
        hard_stop:      1'b0,
        start_match:    SM_NONE,
        enable_before:  1'b0,
        active:         1'b0,
        inhibit:        1'b0
    };

    logic [15:0] plane_control_reg;
    logic [7:0]  fetch_start_reg;
    logic [7:0]  fetch_stop_reg;
    logic        enhanced_mode_reg;
    logic        hard_stop_disable_reg;

    logic        in_valid_reg;
    logic [7:0]  in_hpos_reg;
    logic        in_dma_reg;
    logic        in_win_reg;
    logic        in_clear_reg;

    logic        out_valid_reg;
    logic        out_fetch_valid_reg;
    logic [2:0]  out_plane_reg;
    logic        out_modulo_reg;
    logic        out_active_reg;
    logic        out_inhibit_reg;

    seq_state_t  st_reg;
    seq_state_t  st_ctl;
    seq_state_t  st_next;
    plane_req_t  line_reg  [DEPTH];
    plane_req_t  line_ctl  [DEPTH];
    plane_req_t  line_tmp  [DEPTH];
    plane_req_t  line_next [DEPTH];

    slot_ctx_t   slot_ctx;
    plane_req_t  slot_req;
    plane_req_t  head;
    logic        enable_even;
    logic        advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_control_reg     <= '0;
            fetch_start_reg       <= '0;
            fetch_stop_reg        <= '0;
            enhanced_mode_reg     <= 1'b0;
            hard_stop_disable_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_PLANE_CONTROL:     plane_control_reg     <= cfg_wr_data;
                CFG_FETCH_START:       fetch_start_reg       <= cfg_wr_data[7:0];
                CFG_FETCH_STOP:        fetch_stop_reg        <= cfg_wr_data[7:0];
                CFG_ENHANCED_MODE:     enhanced_mode_reg     <= cfg_wr_data[0];
                CFG_HARD_STOP_DISABLE: hard_stop_disable_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_hpos_reg  <= s_hpos;
            in_dma_reg   <= s_plane_dma_enable;
            in_win_reg   <= s_window_open;
            in_clear_reg <= s_clear_hard_stop;
        end
    end

    // control step
    always_comb begin
        st_ctl           = st_reg;
        st_ctl.hard_stop = st_reg.hard_stop & ~in_clear_reg;
        line_ctl         = line_reg;
        enable_even      = 1'b0;

        case (st_reg.phase)
            PH_START: begin
                st_ctl.phase       = PH_FETCH;
                st_ctl.active      = 1'b1;
                st_ctl.draining    = 1'b0;
                st_ctl.slot        = '0;
                st_ctl.plane_count = plane_control_reg[PC_COUNT_LSB +: 3];
                st_ctl.super_hires = plane_control_reg[PC_SHRES_BIT];
                st_ctl.hires       = !plane_control_reg[PC_SHRES_BIT]
                                     && plane_control_reg[PC_HIRES_BIT];
            end
            PH_FINISH: begin
                st_ctl.phase   = PH_IDLE;
                st_ctl.active  = 1'b0;
                st_ctl.inhibit = 1'b0;
                for (int i = 0; i < DEPTH; i++) begin
                    line_ctl[i] = '0;
                end
            end
            default: ;
        endcase

        if (enhanced_mode_reg) begin
            if (st_ctl.start_match == SM_STOPPED) begin
                st_ctl.start_match = SM_NONE;
                if (st_ctl.phase != PH_IDLE) begin
                    st_ctl.stop_pending = 1'b1;
                end
            end
            if (in_hpos_reg == fetch_start_reg) begin
                st_ctl.start_match = SM_ARMED;
            end
            if (in_hpos_reg == fetch_stop_reg) begin
                if (st_ctl.phase != PH_IDLE) begin
                    st_ctl.stop_pending = 1'b1;
                end
                if (fetch_start_reg != fetch_stop_reg && st_ctl.start_match != SM_NONE) begin
                    st_ctl.start_match = SM_STOPPED;
                end
            end
            if (!in_hpos_reg[0]) begin
                enable_even = in_dma_reg && in_win_reg && st_ctl.start_match[0]
                              && (!st_ctl.hard_stop || hard_stop_disable_reg);
                if (st_ctl.phase == PH_IDLE && enable_even && !st_ctl.enable_before) begin
                    st_ctl.phase   = PH_START;
                    st_ctl.inhibit = 1'b1;
                end
                st_ctl.enable_before = enable_even;
            end
        end else begin
            if (st_ctl.phase != PH_IDLE && in_hpos_reg == fetch_stop_reg) begin
                st_ctl.stop_pending = 1'b1;
            end
            if (st_ctl.phase == PH_IDLE && !st_ctl.hard_stop
                && in_hpos_reg == fetch_start_reg && in_dma_reg && in_win_reg) begin
                st_ctl.phase   = PH_START;
                st_ctl.inhibit = 1'b1;
            end
        end

        if (st_reg.phase == PH_STOP) begin
            st_ctl.phase = PH_FINISH;
            if (st_ctl.stop_pending) begin
                st_ctl.modulo_pending = 1'b1;
            end else if (enhanced_mode_reg) begin
                st_ctl.stop_pending = 1'b1;
            end
        end else if (st_reg.phase == PH_FETCH && !(in_dma_reg && in_win_reg)) begin
            st_ctl.phase = PH_STOP;
        end
    end

    assign slot_ctx = '{plane_count:    st_ctl.plane_count,
                        hires:          st_ctl.hires,
                        super_hires:    st_ctl.super_hires,
                        modulo_pending: st_ctl.modulo_pending};

    bfss_slot_decode u_slot_decode (
        .ctx  (slot_ctx),
        .slot (st_ctl.slot),
        .req  (slot_req)
    );

    // slot step
    always_comb begin
        logic shift;
        st_next   = st_ctl;
        line_tmp  = line_ctl;
        line_next = line_ctl;
        head      = '0;
        shift     = 1'b0;

        if (st_ctl.active) begin
            shift = 1'b1;
            if (st_ctl.draining) begin
                st_next.slot = st_ctl.slot + 4'd1;
                if (st_ctl.slot == 4'd3) begin
                    st_next.active = 1'b0;
                    shift          = 1'b0;
                end
            end else begin
                line_tmp[REQUEST_DELAY] = line_ctl[REQUEST_DELAY] | slot_req;
                if (st_ctl.slot == 4'd7) begin
                    st_next.slot = '0;
                    if (!st_ctl.modulo_pending) begin
                        if (st_ctl.stop_pending) begin
                            st_next.modulo_pending = 1'b1;
                        end
                    end else begin
                        st_next.stop_pending   = 1'b0;
                        st_next.draining       = 1'b1;
                        st_next.modulo_pending = 1'b0;
                        st_next.plane_count    = '0;
                        st_next.hires          = 1'b0;
                        st_next.super_hires    = 1'b0;
                        st_next.inhibit        = 1'b0;
                        if (st_ctl.phase != PH_FINISH) begin
                            st_next.phase = PH_IDLE;
                        end
                        if (!enhanced_mode_reg) begin
                            st_next.hard_stop = 1'b1;
                        end
                    end
                end else begin
                    st_next.slot = st_ctl.slot + 4'd1;
                end
            end
        end

        if (shift) begin
            head = line_tmp[0];
            for (int i = 0; i < DEPTH - 1; i++) begin
                line_next[i] = line_tmp[i+1];
            end
            line_next[DEPTH-1] = '0;
        end else begin
            line_next = line_tmp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_RESET;
            for (int i = 0; i < DEPTH; i++) begin
                line_reg[i] <= '0;
            end
        end else if (advance) begin
            st_reg   <= st_next;
            line_reg <= line_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            if (head.plane != 3'd0 && head.plane != 3'd7) begin
                out_fetch_valid_reg <= 1'b1;
                out_plane_reg       <= head.plane;
                out_modulo_reg      <= head.modulo;
            end else begin
                out_fetch_valid_reg <= 1'b0;
                out_plane_reg       <= '0;
                out_modulo_reg      <= 1'b0;
            end
            out_active_reg  <= st_next.active;
            out_inhibit_reg <= st_next.inhibit;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_fetch_valid    = out_fetch_valid_reg;
    assign m_fetch_plane    = out_plane_reg;
    assign m_add_modulo     = out_modulo_reg;
    assign m_dma_active     = out_active_reg;
    assign m_sprite_inhibit = out_inhibit_reg;

    a_fetch_while_active: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_fetch_valid) |-> m_dma_active
    ) else $error("fetch issued while sequencing inactive");

    a_inhibit_needs_phase: assert property (
        @(posedge aclk) disable iff (!aresetn)
        st_reg.inhibit |-> (st_reg.phase != PH_IDLE)
    ) else $error("sprite inhibit held with fetch machine idle");

    a_drain_bound: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (st_reg.draining && st_reg.active) |-> (st_reg.slot <= 4'd3)
    ) else $error("drain counter ran past the delay line");

    a_start_to_fetch: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (advance && st_reg.phase == PH_START) |=> (st_reg.phase == PH_FETCH && st_reg.active)
    ) else $error("start phase did not enter fetching");

endmodule
